>>> rtl/yqr_pkg.sv
package yqr_pkg;

  // configuration register indexes
  localparam logic CFG_DEPTH_MODE = 1'b0;
  localparam logic CFG_STUDIO     = 1'b1;

  // depth mode codes; the spare code behaves like the 16 bit one
  localparam logic [1:0] DEPTH_8B  = 2'd0;
  localparam logic [1:0] DEPTH_10B = 2'd1;

  localparam logic [15:0] LUMA_BLACK   = 16'd16;
  localparam logic [7:0]  CHROMA_ZERO  = 8'd128;
  // floor(2^32 / 219), estimate is low by at most one
  localparam logic [24:0] LUMA_RECIP   = 25'd19611722;
  localparam logic [7:0]  LUMA_DIV     = 8'd219;
  // ceil(2^16 / 7), exact for numerators below 1872
  localparam logic [13:0] CHROMA_RECIP = 14'd9363;

  localparam logic signed [26:0] COEF_RV = 27'sd91880;
  localparam logic signed [26:0] COEF_GU = 27'sd22580;
  localparam logic signed [26:0] COEF_GV = 27'sd46799;
  localparam logic signed [26:0] COEF_BU = 27'sd116128;

  typedef struct packed {
    logic valid;
    logic studio;
  } ctl_t;

  typedef struct packed {
    logic [15:0] ys;    // shifted luma
    logic        neg;   // below black level
    logic [23:0] mag;   // |y - 16| * 255
  } luma_pre_t;

  typedef struct packed {
    logic [7:0]  c;     // two's complement of sample - 128
    logic        neg;
    logic [14:0] mag;   // |c| * 255
  } chroma_pre_t;

  typedef struct packed {
    luma_pre_t   pre;
    logic [16:0] q_est;
  } luma_div_t;

  typedef struct packed {
    chroma_pre_t pre;
    logic [7:0]  q;
  } chroma_div_t;

  typedef logic signed [17:0] luma_t;
  typedef logic signed [8:0]  chroma_t;
  typedef logic signed [26:0] term_t;
  typedef logic [2:0][7:0]    rgb_t;

  function automatic logic [15:0] sample_shift(input logic [15:0] raw, input logic [1:0] mode);
    logic [15:0] res;
    case (mode)
      DEPTH_8B:  res = raw;
      DEPTH_10B: res = raw >> 2;
      default:   res = raw >> 8;
    endcase
    return res;
  endfunction

  // signed 20.16 value to 8 bits: fraction truncated, integer part saturated to 0..255
  function automatic logic [7:0] clamp_channel(input logic signed [35:0] x);
    logic [7:0] res;
    if (x > 36'sh0FFFFFF) begin
      res = 8'd255;
    end else if (x <= 36'sh000FFFF) begin
      res = 8'd0;
    end else begin
      res = x[23:16];
    end
    return res;
  endfunction

endpackage

>>> rtl/yuv_quad_to_rgb.sv
// channel   direction  handshake              payload
// in_       input      in_valid / in_ready    four 16 bit luma, 16 bit u and v
// out_      output     out_valid / out_ready  four pixels of 8 bit red, green, blue
// cfg_      input      cfg_we                 cfg_index selects, cfg_wdata 2 bits
//
// one quad per cycle unless the output stalls; each accepted request passes through
// the five register stages in order: unpack, reciprocal multiply, divide correction,
// chroma products, sum and clamp into the output register
// a stalled output freezes every stage at once; in_ready is low only then
// synchronous reset clears the stage valid bits and both registers
module yuv_quad_to_rgb import yqr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_luma_top_left,
  input  logic [15:0] in_luma_top_right,
  input  logic [15:0] in_luma_bottom_left,
  input  logic [15:0] in_luma_bottom_right,
  input  logic [15:0] in_chroma_u_sample,
  input  logic [15:0] in_chroma_v_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red_top_left,
  output logic [7:0]  out_green_top_left,
  output logic [7:0]  out_blue_top_left,
  output logic [7:0]  out_red_top_right,
  output logic [7:0]  out_green_top_right,
  output logic [7:0]  out_blue_top_right,
  output logic [7:0]  out_red_bottom_left,
  output logic [7:0]  out_green_bottom_left,
  output logic [7:0]  out_blue_bottom_left,
  output logic [7:0]  out_red_bottom_right,
  output logic [7:0]  out_green_bottom_right,
  output logic [7:0]  out_blue_bottom_right,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [1:0]  cfg_wdata
);

  logic [1:0]         depth_mode_r;
  logic               studio_r;
  logic               en;
  ctl_t               in_ctl;
  ctl_t               s1_ctl, s3_ctl, s5_ctl;
  luma_pre_t   [3:0]  s1_luma;
  chroma_pre_t        s1_u, s1_v;
  luma_t       [3:0]  s3_luma;
  chroma_t            s3_u, s3_v;
  rgb_t        [3:0]  pix;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_mode_r <= DEPTH_8B;
      studio_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEPTH_MODE: depth_mode_r <= cfg_wdata;
        CFG_STUDIO:     studio_r     <= cfg_wdata[0];
        default:        ;
      endcase
    end
  end

  assign en            = !s5_ctl.valid || out_ready;
  assign in_ready      = en;
  assign in_ctl.valid  = in_valid;
  assign in_ctl.studio = studio_r;

  yqr_unpack u_unpack (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .ctl_in     (in_ctl),
    .depth_mode (depth_mode_r),
    .luma_raw   ({in_luma_bottom_right, in_luma_bottom_left,
                  in_luma_top_right, in_luma_top_left}),
    .u_raw      (in_chroma_u_sample),
    .v_raw      (in_chroma_v_sample),
    .ctl_out    (s1_ctl),
    .luma_out   (s1_luma),
    .u_out      (s1_u),
    .v_out      (s1_v)
  );

  yqr_expand u_expand (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .ctl_in   (s1_ctl),
    .luma_in  (s1_luma),
    .u_in     (s1_u),
    .v_in     (s1_v),
    .ctl_out  (s3_ctl),
    .luma_out (s3_luma),
    .u_out    (s3_u),
    .v_out    (s3_v)
  );

  yqr_mix u_mix (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ctl_in  (s3_ctl),
    .luma_in (s3_luma),
    .u_in    (s3_u),
    .v_in    (s3_v),
    .ctl_out (s5_ctl),
    .pix_out (pix)
  );

  assign out_valid              = s5_ctl.valid;
  assign out_red_top_left       = pix[0][0];
  assign out_green_top_left     = pix[0][1];
  assign out_blue_top_left      = pix[0][2];
  assign out_red_top_right      = pix[1][0];
  assign out_green_top_right    = pix[1][1];
  assign out_blue_top_right     = pix[1][2];
  assign out_red_bottom_left    = pix[2][0];
  assign out_green_bottom_left  = pix[2][1];
  assign out_blue_bottom_left   = pix[2][2];
  assign out_red_bottom_right   = pix[3][0];
  assign out_green_bottom_right = pix[3][1];
  assign out_blue_bottom_right  = pix[3][2];

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(s3_ctl.valid, 2))
    else $error("output valid without an item in flight");

  // in studio mode, expanded top left and bottom right luma stays within the studio mapping of a 16 bit sample
  a_luma_range: assert property (@(posedge clk) disable iff (!rst_n)
    s3_ctl.valid && s3_ctl.studio |->
      $signed(s3_luma[0]) >= -18 && $signed(s3_luma[0]) <= 76289 &&
      $signed(s3_luma[3]) >= -18 && $signed(s3_luma[3]) <= 76289)
    else $error("expanded luma out of range");

  a_chroma_range: assert property (@(posedge clk) disable iff (!rst_n)
    s3_ctl.valid && s3_ctl.studio |->
      $signed(s3_u) >= -145 && $signed(s3_u) <= 144 &&
      $signed(s3_v) >= -145 && $signed(s3_v) <= 144)
    else $error("expanded chroma out of range");

endmodule

>>> rtl/yqr_unpack.sv
module yqr_unpack import yqr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  ctl_t                   ctl_in,
  input  logic [1:0]             depth_mode,
  input  logic [3:0][15:0]       luma_raw,
  input  logic [15:0]            u_raw,
  input  logic [15:0]            v_raw,
  output ctl_t                   ctl_out,
  output luma_pre_t [3:0]        luma_out,
  output chroma_pre_t            u_out,
  output chroma_pre_t            v_out
);

  ctl_t                ctl_r;
  luma_pre_t   [3:0]   luma_r, luma_nxt;
  chroma_pre_t         u_r, u_nxt, v_r, v_nxt;

  function automatic chroma_pre_t chroma_prep(input logic [15:0] raw, input logic [1:0] mode);
    chroma_pre_t res;
    logic [15:0] cs;
    logic [7:0]  c8;
    logic [7:0]  abs_c;
    logic [15:0] prod;
    cs        = sample_shift(raw, mode);
    c8        = cs[7:0];
    res.c     = {~c8[7], c8[6:0]};
    res.neg   = ~c8[7];
    abs_c     = res.neg ? (CHROMA_ZERO - c8) : (c8 - CHROMA_ZERO);
    prod      = {abs_c, 8'd0} - {8'd0, abs_c};
    res.mag   = prod[14:0];
    return res;
  endfunction

  always_comb begin
    logic [15:0] nm;
    for (int k = 0; k < 4; k++) begin
      luma_nxt[k].ys  = sample_shift(luma_raw[k], depth_mode);
      luma_nxt[k].neg = luma_nxt[k].ys < LUMA_BLACK;
      nm = luma_nxt[k].neg ? (LUMA_BLACK - luma_nxt[k].ys) : (luma_nxt[k].ys - LUMA_BLACK);
      luma_nxt[k].mag = {nm, 8'd0} - {8'd0, nm};
    end
    u_nxt = chroma_prep(u_raw, depth_mode);
    v_nxt = chroma_prep(v_raw, depth_mode);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      luma_r <= luma_nxt;
      u_r    <= u_nxt;
      v_r    <= v_nxt;
    end
  end

  assign ctl_out  = ctl_r;
  assign luma_out = luma_r;
  assign u_out    = u_r;
  assign v_out    = v_r;

endmodule

>>> rtl/yqr_expand.sv
module yqr_expand import yqr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  ctl_t                 ctl_in,
  input  luma_pre_t   [3:0]    luma_in,
  input  chroma_pre_t          u_in,
  input  chroma_pre_t          v_in,
  output ctl_t                 ctl_out,
  output luma_t       [3:0]    luma_out,
  output chroma_t              u_out,
  output chroma_t              v_out
);

  // first stage: reciprocal multiplies
  ctl_t               ctl1_r;
  luma_div_t   [3:0]  ld_r, ld_nxt;
  chroma_div_t        ud_r, ud_nxt, vd_r, vd_nxt;

  // second stage: correction, sign and range select
  ctl_t               ctl2_r;
  luma_t       [3:0]  y_r, y_nxt;
  chroma_t            u_r, u_nxt, v_r, v_nxt;

  function automatic chroma_div_t chroma_div(input chroma_pre_t p);
    chroma_div_t res;
    logic [23:0] prod;
    // divide by 32 then by 7
    prod    = 24'(p.mag[14:5]) * 24'(CHROMA_RECIP);
    res.pre = p;
    res.q   = prod[23:16];
    return res;
  endfunction

  function automatic chroma_t chroma_fin(input chroma_div_t d, input logic studio);
    chroma_t q9;
    chroma_t res;
    q9 = $signed({1'b0, d.q});
    if (studio) begin
      res = d.pre.neg ? -q9 : q9;
    end else begin
      res = $signed({d.pre.c[7], d.pre.c});
    end
    return res;
  endfunction

  always_comb begin
    logic [48:0] prod;
    for (int k = 0; k < 4; k++) begin
      prod            = 49'(luma_in[k].mag) * 49'(LUMA_RECIP);
      ld_nxt[k].pre   = luma_in[k];
      ld_nxt[k].q_est = prod[48:32];
    end
    ud_nxt = chroma_div(u_in);
    vd_nxt = chroma_div(v_in);
  end

  always_comb begin
    logic [24:0] back;
    logic [24:0] rem;
    logic [16:0] q;
    luma_t       qs;
    for (int k = 0; k < 4; k++) begin
      back = 25'(ld_r[k].q_est) * 25'(LUMA_DIV);
      rem  = 25'(ld_r[k].pre.mag) - back;
      q    = ld_r[k].q_est + 17'(rem >= 25'(LUMA_DIV));
      qs   = $signed({1'b0, q});
      if (ctl1_r.studio) begin
        y_nxt[k] = ld_r[k].pre.neg ? -qs : qs;
      end else begin
        y_nxt[k] = $signed({2'b00, ld_r[k].pre.ys});
      end
    end
    u_nxt = chroma_fin(ud_r, ctl1_r.studio);
    v_nxt = chroma_fin(vd_r, ctl1_r.studio);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
    end else if (en) begin
      ctl1_r <= ctl_in;
      ctl2_r <= ctl1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ld_r <= ld_nxt;
      ud_r <= ud_nxt;
      vd_r <= vd_nxt;
      y_r  <= y_nxt;
      u_r  <= u_nxt;
      v_r  <= v_nxt;
    end
  end

  assign ctl_out  = ctl2_r;
  assign luma_out = y_r;
  assign u_out    = u_r;
  assign v_out    = v_r;

endmodule

>>> rtl/yqr_mix.sv
module yqr_mix import yqr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  ctl_t             ctl_in,
  input  luma_t   [3:0]    luma_in,
  input  chroma_t          u_in,
  input  chroma_t          v_in,
  output ctl_t             ctl_out,
  output rgb_t    [3:0]    pix_out
);

  // chroma terms are shared by the four pixels
  ctl_t            ctl1_r;
  luma_t   [3:0]   y_r;
  term_t           rv_r, rv_nxt, gu_r, gu_nxt, gv_r, gv_nxt, bu_r, bu_nxt;

  ctl_t            ctl2_r;
  rgb_t    [3:0]   pix_r, pix_nxt;

  always_comb begin
    term_t ue;
    term_t ve;
    ue     = 27'($signed(u_in));
    ve     = 27'($signed(v_in));
    rv_nxt = ve * COEF_RV;
    gu_nxt = ue * COEF_GU;
    gv_nxt = ve * COEF_GV;
    bu_nxt = ue * COEF_BU;
  end

  always_comb begin
    logic signed [35:0] ysh;
    logic signed [35:0] rs;
    logic signed [35:0] gs;
    logic signed [35:0] bs;
    for (int k = 0; k < 4; k++) begin
      ysh = 36'($signed(y_r[k])) <<< 16;
      rs  = ysh + 36'($signed(rv_r));
      gs  = ysh - 36'($signed(gu_r)) - 36'($signed(gv_r));
      bs  = ysh + 36'($signed(bu_r));
      pix_nxt[k][0] = clamp_channel(rs);
      pix_nxt[k][1] = clamp_channel(gs);
      pix_nxt[k][2] = clamp_channel(bs);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
    end else if (en) begin
      ctl1_r <= ctl_in;
      ctl2_r <= ctl1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_r   <= luma_in;
      rv_r  <= rv_nxt;
      gu_r  <= gu_nxt;
      gv_r  <= gv_nxt;
      bu_r  <= bu_nxt;
      pix_r <= pix_nxt;
    end
  end

  assign ctl_out = ctl2_r;
  assign pix_out = pix_r;

endmodule
